/* hdl/tdba_pkg.sv */
// ----------------------------------------------------------------------------
// tdba_pkg
// Shared codes for the telemetry dual block averager: channel tags, record
// kinds and the channel count.
// ----------------------------------------------------------------------------
package tdba_pkg;

    // Number of tracked telemetry channels
    localparam int NUM_CH = 4;

    // Channel tag carried on the input tuser
    typedef enum logic [2:0] {
        CH_SPEED = 3'd0,
        CH_ACCEL = 3'd1,
        CH_PITCH = 3'd2,
        CH_ROLL  = 3'd3,
        CH_OTHER = 3'd4
    } t_chan;

    // Record kind carried on the output tuser
    typedef enum logic {
        REC_LOG     = 1'b0,
        REC_DISPLAY = 1'b1
    } t_rec_kind;

endpackage

/* hdl/telemetry_dual_block_averager.sv */
// ----------------------------------------------------------------------------
// telemetry_dual_block_averager
// Keeps the latest speed, acceleration, pitch and roll, and emits log and
// display records of their block averages.
// ----------------------------------------------------------------------------
// The block takes one tagged sample per item on the slave stream, at one item
// per clock unless a window-closing item waits for the result register. Each
// item updates the latest value of its channel (tags other than the four
// channels update nothing) and then adds all four latest values to a log and
// a display accumulator. The item that closes a log window (LOG_WINDOW items)
// yields a log record; the item that closes a display window (DISPLAY_WINDOW
// items) yields a display record, and its averages replace the latest values.
// When one item closes both, the log record leaves first and only the display
// record carries tlast. Averages truncate toward zero; acceleration is signed
// Q8.8. An item waits in the input register and is processed as it moves on,
// loading its records into the result register, from which the master stream
// presents them. The result register holds the records of one item; an item
// closing both windows presents its two records in turn, during which a
// following item that also closes a window waits in the input register, while
// items that close no window keep flowing at one per clock.
// ----------------------------------------------------------------------------
module telemetry_dual_block_averager
    import tdba_pkg::*;
#(
    parameter int LOG_WINDOW     = 2,
    parameter int DISPLAY_WINDOW = 8,
    parameter int SAMPLE_WIDTH   = 16,
    localparam int IN_DATA_W     = ((SAMPLE_WIDTH + 32 + 7) / 8) * 8,
    localparam int OUT_DATA_W    = ((32 + NUM_CH * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: sample_value [SAMPLE_WIDTH], time_stamp [32], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: channel [3]
    input  logic [2:0]            s_axis_tuser,
    // Master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: record_time [32], avg_speed, avg_accel, avg_pitch, avg_roll
    //        [SAMPLE_WIDTH each], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: record_kind [1]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int OUT_PAD_W  = OUT_DATA_W - 32 - NUM_CH * SAMPLE_WIDTH;
    localparam int LSUM_W     = SAMPLE_WIDTH + $clog2(LOG_WINDOW);
    localparam int DSUM_W     = SAMPLE_WIDTH + $clog2(DISPLAY_WINDOW);
    localparam int LCNT_W     = $clog2(LOG_WINDOW);
    localparam int DCNT_W     = $clog2(DISPLAY_WINDOW);

    // Input register
    logic                           r_in_valid;
    t_chan                          r_in_ch;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;
    logic [31:0]                    r_in_time;

    // Averaging state
    logic signed [SAMPLE_WIDTH-1:0] r_latest   [NUM_CH];
    logic signed [LSUM_W-1:0]       r_log_sum  [NUM_CH];
    logic signed [DSUM_W-1:0]       r_disp_sum [NUM_CH];
    logic [LCNT_W-1:0]              r_log_cnt;
    logic [DCNT_W-1:0]              r_disp_cnt;

    // Result register
    logic                           r_log_v;
    logic                           r_disp_v;
    logic [31:0]                    r_rec_time;
    logic signed [SAMPLE_WIDTH-1:0] r_log_avg  [NUM_CH];
    logic signed [SAMPLE_WIDTH-1:0] r_disp_avg [NUM_CH];

    // Next values
    logic signed [SAMPLE_WIDTH-1:0] n_latest   [NUM_CH];
    logic signed [LSUM_W-1:0]       n_log_sum  [NUM_CH];
    logic signed [DSUM_W-1:0]       n_disp_sum [NUM_CH];
    logic signed [SAMPLE_WIDTH-1:0] n_log_avg  [NUM_CH];
    logic signed [SAMPLE_WIDTH-1:0] n_disp_avg [NUM_CH];

    logic w_log_close;
    logic w_disp_close;
    logic w_has_res;
    logic w_out_take;
    logic w_res_free;
    logic w_move;

    // Window closing and handshake control
    assign w_log_close  = (r_log_cnt == LCNT_W'(LOG_WINDOW - 1));
    assign w_disp_close = (r_disp_cnt == DCNT_W'(DISPLAY_WINDOW - 1));
    assign w_has_res    = w_log_close | w_disp_close;
    assign w_out_take   = m_axis_tvalid & m_axis_tready;
    assign w_res_free   = !(r_log_v | r_disp_v) || (w_out_take && !(r_log_v && r_disp_v));
    assign w_move       = r_in_valid && (!w_has_res || w_res_free);
    assign s_axis_tready = !r_in_valid || w_move;

    // Update, accumulate and average per channel
    generate
        for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
            assign n_latest[k] = (r_in_ch == t_chan'(k)) ? r_in_sample : r_latest[k];
            assign n_log_sum[k]  = r_log_sum[k]  + LSUM_W'(n_latest[k]);
            assign n_disp_sum[k] = r_disp_sum[k] + DSUM_W'(n_latest[k]);

            tdba_avg_div #(
                .WINDOW (LOG_WINDOW),
                .SUM_W  (LSUM_W),
                .OUT_W  (SAMPLE_WIDTH)
            ) u_log_div (
                .i_sum  (n_log_sum[k]),
                .o_avg  (n_log_avg[k])
            );

            tdba_avg_div #(
                .WINDOW (DISPLAY_WINDOW),
                .SUM_W  (DSUM_W),
                .OUT_W  (SAMPLE_WIDTH)
            ) u_disp_div (
                .i_sum  (n_disp_sum[k]),
                .o_avg  (n_disp_avg[k])
            );
        end
    endgenerate

    // Hold the accepted item until it moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch     <= t_chan'(s_axis_tuser);
            r_in_sample <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            r_in_time   <= s_axis_tdata[SAMPLE_WIDTH +: 32];
        end
    end

    // Advance accumulators and latest values as the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_cnt  <= '0;
            r_disp_cnt <= '0;
            for (int k = 0; k < NUM_CH; k++) begin
                r_latest[k]   <= '0;
                r_log_sum[k]  <= '0;
                r_disp_sum[k] <= '0;
            end
        end else if (w_move) begin
            r_log_cnt  <= w_log_close  ? '0 : r_log_cnt + 1'b1;
            r_disp_cnt <= w_disp_close ? '0 : r_disp_cnt + 1'b1;
            for (int k = 0; k < NUM_CH; k++) begin
                r_latest[k]   <= w_disp_close ? n_disp_avg[k] : n_latest[k];
                r_log_sum[k]  <= w_log_close  ? '0 : n_log_sum[k];
                r_disp_sum[k] <= w_disp_close ? '0 : n_disp_sum[k];
            end
        end
    end

    // Load records into the result register, drop each once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_v  <= 1'b0;
            r_disp_v <= 1'b0;
        end else if (w_move && w_has_res) begin
            r_log_v  <= w_log_close;
            r_disp_v <= w_disp_close;
        end else if (w_out_take) begin
            if (r_log_v) begin
                r_log_v <= 1'b0;
            end else begin
                r_disp_v <= 1'b0;
            end
        end
        if (w_move && w_has_res) begin
            r_rec_time <= r_in_time;
            for (int k = 0; k < NUM_CH; k++) begin
                r_log_avg[k]  <= n_log_avg[k];
                r_disp_avg[k] <= n_disp_avg[k];
            end
        end
    end

    // Present the log record first, then the display record
    assign m_axis_tvalid = r_log_v | r_disp_v;
    assign m_axis_tuser  = r_log_v ? REC_LOG : REC_DISPLAY;
    assign m_axis_tlast  = !(r_log_v && r_disp_v);

    generate
        if (OUT_PAD_W > 0) begin : g_out_pad
            assign m_axis_tdata[OUT_DATA_W-1 -: OUT_PAD_W] = '0;
        end
    endgenerate

    assign m_axis_tdata[31:0] = r_rec_time;

    generate
        for (genvar k = 0; k < NUM_CH; k++) begin : g_out
            assign m_axis_tdata[32 + k*SAMPLE_WIDTH +: SAMPLE_WIDTH] =
                r_log_v ? r_log_avg[k] : r_disp_avg[k];
        end
    endgenerate

endmodule

/* hdl/tdba_avg_div.sv */
// ----------------------------------------------------------------------------
// tdba_avg_div
// Divides a signed block sum by a constant window, truncating toward zero.
// Power-of-two windows use a shift; other windows use an exact reciprocal
// multiply on the magnitude.
// ----------------------------------------------------------------------------
module tdba_avg_div #(
    parameter int WINDOW = 8,
    parameter int SUM_W  = 19,
    parameter int OUT_W  = 16
) (
    input  logic signed [SUM_W-1:0] i_sum,
    output logic signed [OUT_W-1:0] o_avg
);

    localparam int  SHIFT_L = $clog2(WINDOW);
    localparam bit  IS_POW2 = ((1 << SHIFT_L) == WINDOW);

    logic             w_neg;
    logic [SUM_W-1:0] w_mag;
    logic [SUM_W-1:0] w_quot;

    // Take the magnitude so that the quotient truncates toward zero
    assign w_neg = i_sum[SUM_W-1];
    assign w_mag = w_neg ? SUM_W'(-i_sum) : SUM_W'(i_sum);

    generate
        if (IS_POW2) begin : g_shift
            assign w_quot = w_mag >> SHIFT_L;
        end else begin : g_recip
            // ceil(2^(SUM_W+L) / WINDOW) gives an exact floor for any magnitude
            localparam logic [SUM_W:0] RECIP =
                (SUM_W+1)'(((64'd1 << (SUM_W + SHIFT_L)) + 64'(WINDOW) - 64'd1)
                           / 64'(WINDOW));
            logic [2*SUM_W:0] w_prod;
            assign w_prod = (2*SUM_W+1)'(w_mag) * (2*SUM_W+1)'(RECIP);
            assign w_quot = SUM_W'(w_prod >> (SUM_W + SHIFT_L));
        end
    endgenerate

    // Restore the sign
    assign o_avg = w_neg ? -OUT_W'(w_quot) : OUT_W'(w_quot);

endmodule
